// ===== rtl/core/bta_pkg.sv =====
// Shared types and constants for the block table heap allocator.
// Depends on nothing; imported by bta_table and block_table_heap_allocator.
`timescale 1ns / 1ps

package bta_pkg;

   localparam int BASE_W   = 32;
   localparam int BCOUNT_W = 11;
   localparam int DATA_W   = 32;
   localparam int PADDR_W  = 3;

   // register index, taken from paddr[2]
   localparam logic REG_HEAP_BASE   = 1'b0;
   localparam logic REG_BLOCK_COUNT = 1'b1;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_NOROOM = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 11'd1024;

   typedef struct packed {
      logic first;
      logic next;
      logic taken;
   } tbl_entry_type;

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_NEED   = 9'b000000100,
      S_SCAN   = 9'b000001000,
      S_MARK   = 9'b000010000,
      S_ADDR   = 9'b000100000,
      S_CHECK  = 9'b001000000,
      S_LOCATE = 9'b010000000,
      S_WALK   = 9'b100000000
   } state_type;

endpackage

// ===== rtl/core/bta_table.sv =====
// Block flag table: one write port, one read port with registered data.
// Depends on bta_pkg for the entry type.
`timescale 1ns / 1ps

module bta_table
   import bta_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  tbl_entry_type       wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output tbl_entry_type       rd_data
);

   tbl_entry_type mem [DEPTH];
   tbl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/block_table_heap_allocator.sv =====
// First-fit block table heap allocator: sequencer, shared adder, config regs.
// Allocate: size, scan for a free run, mark, form the address. Free: check the address,
// locate its block, walk the chain. One word per item; busy meanwhile.
// All byte arithmetic runs through one adder; the table has one read and one write port.
// After reset the table is cleared one entry a cycle, all MAX_BLOCKS entries, busy high.
// Each result word is shown for one cycle on rsp_valid; the receiver cannot stall.
`timescale 1ns / 1ps

module block_table_heap_allocator
   import bta_pkg::*;
#(
   parameter int MAX_BLOCKS  = 1024,
   parameter int BLOCK_BYTES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [31:0]         req_alloc_bytes,
   input  logic [31:0]         req_free_addr,
   output logic                rsp_valid,
   output logic [31:0]         rsp_result_addr,
   output logic [1:0]          rsp_status,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int BB_W    = $clog2(BLOCK_BYTES + 1);
   localparam int ACC_RAW = CNT_W + BB_W;
   localparam int ACC_W   = (ACC_RAW > 33) ? ACC_RAW : 33;
   localparam int CMP_W   = (CNT_W > BCOUNT_W) ? CNT_W : BCOUNT_W;
   localparam logic [ACC_W-1:0] BB_C   = ACC_W'(BLOCK_BYTES);
   localparam logic [CNT_W-1:0] LAST_C = CNT_W'(MAX_BLOCKS - 1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic [CNT_W-1:0]     ev_ff, ev_in;
   logic                 ev_vld_ff, ev_vld_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0]     need_ff, need_in;
   logic [CNT_W-1:0]     run_ff, run_in;
   logic [CNT_W-1:0]     start_idx_ff, start_idx_in;
   logic [ACC_W-1:0]     start_off_ff, start_off_in;
   logic [CNT_W-1:0]     end_idx_ff, end_idx_in;
   logic [ACC_W-1:0]     rel_ff, rel_in;
   logic                 action_ff, action_in;
   logic [31:0]          bytes_ff, bytes_in;
   logic [31:0]          addr_ff, addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_addr_ff, rsp_addr_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [BASE_W-1:0]    base_ff;
   logic [BCOUNT_W-1:0]  bcount_ff;

   logic [ACC_W-1:0]     add_a, add_b, sum;
   logic                 add_cin;
   logic [CMP_W-1:0]     bc_ext, max_ext;
   logic [CNT_W-1:0]     n_use;
   logic                 tbl_wr_en;
   logic [IDX_W-1:0]     tbl_wr_addr;
   tbl_entry_type        tbl_wr_data, tbl_rd_data;
   logic [CNT_W-1:0]     start_now;
   logic [ACC_W-1:0]     start_off_now;
   logic                 accept, cfg_wr;

   assign accept = start && !busy;
   assign cfg_wr = psel && penable && pwrite && pready;

   // blocks in use
   assign bc_ext  = CMP_W'(bcount_ff);
   assign max_ext = CMP_W'(MAX_BLOCKS);
   assign n_use   = CNT_W'((bc_ext < max_ext) ? bc_ext : max_ext);

   // shared adder
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_cin = 1'b0;
      unique case (state_ff)
         S_NEED, S_SCAN, S_LOCATE: begin
            add_a = acc_ff;
            add_b = BB_C;
         end
         S_CHECK: begin
            add_a   = ACC_W'(addr_ff);
            add_b   = ~ACC_W'(base_ff);
            add_cin = 1'b1;
         end
         S_ADDR: begin
            add_a = ACC_W'(base_ff);
            add_b = start_off_ff;
         end
         default: begin
         end
      endcase
      sum = add_a + add_b + ACC_W'(add_cin);
   end

   assign start_now     = (run_ff == '0) ? ev_ff : start_idx_ff;
   assign start_off_now = (run_ff == '0) ? acc_ff : start_off_ff;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      ev_in         = ev_ff;
      ev_vld_in     = ev_vld_ff;
      acc_in        = acc_ff;
      need_in       = need_ff;
      run_in        = run_ff;
      start_idx_in  = start_idx_ff;
      start_off_in  = start_off_ff;
      end_idx_in    = end_idx_ff;
      rel_in        = rel_ff;
      action_in     = action_ff;
      bytes_in      = bytes_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = ptr_ff[IDX_W-1:0];
      tbl_wr_data   = '0;

      unique case (state_ff)
         S_CLEAR: begin
            tbl_wr_en = 1'b1;
            if (ptr_ff == LAST_C) begin
               ptr_in   = '0;
               state_in = S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               action_in = req_action;
               bytes_in  = req_alloc_bytes;
               addr_in   = req_free_addr;
               acc_in    = '0;
               need_in   = '0;
               state_in  = (req_action == ACT_FREE) ? S_CHECK : S_NEED;
            end
         end
         S_NEED: begin
            if (bytes_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ST_REJECT;
               state_in      = S_IDLE;
            end else if (acc_ff >= ACC_W'(bytes_ff)) begin
               acc_in    = '0;
               ptr_in    = '0;
               ev_vld_in = 1'b0;
               run_in    = '0;
               state_in  = S_SCAN;
            end else if (need_ff == n_use) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ST_NOROOM;
               state_in      = S_IDLE;
            end else begin
               acc_in  = sum;
               need_in = need_ff + 1'b1;
            end
         end
         S_SCAN: begin
            ptr_in    = ptr_ff + 1'b1;
            ev_in     = ptr_ff;
            ev_vld_in = 1'b1;
            if (ev_vld_ff) begin
               if (ev_ff == n_use) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = ST_NOROOM;
                  state_in      = S_IDLE;
               end else begin
                  acc_in = sum;
                  if (tbl_rd_data.taken) begin
                     run_in = '0;
                  end else begin
                     run_in       = run_ff + 1'b1;
                     start_idx_in = start_now;
                     start_off_in = start_off_now;
                     if (run_ff + 1'b1 == need_ff) begin
                        end_idx_in = ev_ff;
                        ptr_in     = start_now;
                        state_in   = S_MARK;
                     end
                  end
               end
            end
         end
         S_MARK: begin
            tbl_wr_en         = 1'b1;
            tbl_wr_data.taken = 1'b1;
            tbl_wr_data.next  = (ptr_ff != end_idx_ff);
            tbl_wr_data.first = (ptr_ff == start_idx_ff);
            if (ptr_ff == end_idx_ff) begin
               state_in = S_ADDR;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_ADDR: begin
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = sum[31:0];
            rsp_status_in = ST_DONE;
            state_in      = S_IDLE;
         end
         S_CHECK: begin
            rel_in = sum;
            if (addr_ff == '0 || sum[ACC_W-1]) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ST_REJECT;
               state_in      = S_IDLE;
            end else begin
               acc_in   = '0;
               ptr_in   = '0;
               state_in = S_LOCATE;
            end
         end
         S_LOCATE: begin
            if (ptr_ff == n_use) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ST_REJECT;
               state_in      = S_IDLE;
            end else if (rel_ff < sum) begin
               ev_vld_in = 1'b0;
               state_in  = S_WALK;
            end else begin
               acc_in = sum;
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_WALK: begin
            ptr_in      = ptr_ff + 1'b1;
            ev_in       = ptr_ff;
            ev_vld_in   = 1'b1;
            tbl_wr_addr = ev_ff[IDX_W-1:0];
            if (ev_vld_ff) begin
               if (ev_ff == n_use || !tbl_rd_data.taken) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = ST_DONE;
                  state_in      = S_IDLE;
               end else begin
                  tbl_wr_en = 1'b1;
                  if (!tbl_rd_data.next) begin
                     rsp_valid_in  = 1'b1;
                     rsp_addr_in   = '0;
                     rsp_status_in = ST_DONE;
                     state_in      = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         ev_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         ev_vld_ff    <= ev_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff         <= ev_in;
      acc_ff        <= acc_in;
      need_ff       <= need_in;
      run_ff        <= run_in;
      start_idx_ff  <= start_idx_in;
      start_off_ff  <= start_off_in;
      end_idx_ff    <= end_idx_in;
      rel_ff        <= rel_in;
      action_ff     <= action_in;
      bytes_ff      <= bytes_in;
      addr_ff       <= addr_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         bcount_ff <= BCOUNT_RESET;
      end else if (cfg_wr) begin
         unique case (paddr[2])
            REG_HEAP_BASE:   base_ff   <= pwdata[BASE_W-1:0];
            REG_BLOCK_COUNT: bcount_ff <= pwdata[BCOUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_HEAP_BASE:   prdata = DATA_W'(base_ff);
         REG_BLOCK_COUNT: prdata = DATA_W'(bcount_ff);
         default:         prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   bta_table #(
      .DEPTH  (MAX_BLOCKS),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_status      = rsp_status_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word shown while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not start work");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held more than one cycle");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DONE) |-> (rsp_result_addr == '0))
      else $error("failed word carries an address");

endmodule
